@@ hw/rtl/lru_page_replacement_macros.svh @@
// Assertion macros shared by the checker modules of the LRU page replacement block.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRUP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lrup assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define LRUP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lrup assertion failed one cycle later");

`endif

@@ hw/rtl/lrup_pkg.sv @@
// Shared constants, codes and types of the LRU page replacement block.
package lrup_pkg;

    localparam int MAX_FRAMES_DEF   = 32;
    localparam int PAGE_BITS_DEF    = 6;
    localparam int ADDRESS_BITS_DEF = 15;

    localparam int KB_SHIFT    = 10;
    localparam int COUNT_W     = 16;
    localparam int PSL_W       = 2;
    localparam int FA_W        = 6;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;

    localparam logic [PSL_W-1:0] PSL_RESET = '0;
    localparam logic [FA_W-1:0]  FA_RESET  = FA_W'(4);

    localparam logic KIND_REFERENCE = 1'b0;
    localparam logic KIND_CLEAR     = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PAGE_SIZE_LOG2  = 2'd0,
        CFG_FRAMES_ASSIGNED = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [PSL_W-1:0] page_size_log2;
        logic [FA_W-1:0]  frames_assigned;
    } lrup_cfg_t;

endpackage

@@ hw/rtl/lrup_stack.sv @@
// Recency stack storage: one write port and one registered read port.
module lrup_stack #(
    parameter int DEPTH = lrup_pkg::MAX_FRAMES_DEF,
    parameter int WIDTH = lrup_pkg::PAGE_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/lrup_seq.sv @@
// Sequencer that searches and shifts the recency stack one entry per step.
module lrup_seq #(
    parameter int MAX_FRAMES   = lrup_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS    = lrup_pkg::PAGE_BITS_DEF,
    parameter int ADDRESS_BITS = lrup_pkg::ADDRESS_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lrup_pkg::lrup_cfg_t            cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_kind,
    input  logic [ADDRESS_BITS-1:0]        in_address,
    output logic                           res_valid,
    input  logic                           res_ready,
    output logic                           res_hit,
    output logic [PAGE_BITS-1:0]           res_page,
    output logic                           res_ev_valid,
    output logic [PAGE_BITS-1:0]           res_ev_page,
    output logic [lrup_pkg::COUNT_W-1:0]   res_hit_total,
    output logic [lrup_pkg::COUNT_W-1:0]   res_ref_total
);
    import lrup_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int IDX_W = $clog2(MAX_FRAMES);
    localparam int LIM_W = (CNT_W > FA_W) ? CNT_W : FA_W;
    localparam int SUM_W = (ADDRESS_BITS + 1 > PAGE_BITS) ? ADDRESS_BITS + 1 : PAGE_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [PAGE_BITS-1:0] pg_reg, pg_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic                 hit_reg, hit_next;
    logic                 evv_reg, evv_next;
    logic [PAGE_BITS-1:0] evp_reg, evp_next;
    logic [COUNT_W-1:0]   hit_cnt_reg, hit_cnt_next;
    logic [COUNT_W-1:0]   ref_cnt_reg, ref_cnt_next;

    logic [ADDRESS_BITS-1:0] addr_m1;
    logic [ADDRESS_BITS-1:0] addr_shifted;
    logic [4:0]              shift_amt;
    logic [SUM_W-1:0]        page_sum;
    logic [PAGE_BITS-1:0]    page_calc;
    logic [LIM_W-1:0]        fa_ext;
    logic [CNT_W-1:0]        lim;
    logic [CNT_W-1:0]        used_m1;
    logic [CNT_W-1:0]        cnt_p1;
    logic [COUNT_W-1:0]      hit_cnt_inc;
    logic [COUNT_W-1:0]      ref_cnt_inc;

    logic                 mem_wr_en;
    logic [IDX_W-1:0]     mem_wr_addr;
    logic [PAGE_BITS-1:0] mem_wr_data;
    logic [IDX_W-1:0]     mem_rd_addr;
    logic [PAGE_BITS-1:0] mem_rd_data;

    lrup_stack #(
        .DEPTH (MAX_FRAMES),
        .WIDTH (PAGE_BITS)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_comb begin
        addr_m1      = in_address - 1'b1;
        shift_amt    = 5'(KB_SHIFT) + 5'(cfg.page_size_log2);
        addr_shifted = addr_m1 >> shift_amt;
        page_sum     = SUM_W'(addr_shifted) + SUM_W'(1);
        page_calc    = (in_address == '0) ? PAGE_BITS'(1) : page_sum[PAGE_BITS-1:0];

        fa_ext = LIM_W'(cfg.frames_assigned);
        if (cfg.frames_assigned == '0) begin
            lim = CNT_W'(1);
        end else if (fa_ext > LIM_W'(MAX_FRAMES)) begin
            lim = CNT_W'(MAX_FRAMES);
        end else begin
            lim = CNT_W'(fa_ext);
        end

        used_m1     = used_reg - 1'b1;
        cnt_p1      = cnt_reg + 1'b1;
        hit_cnt_inc = (hit_cnt_reg == '1) ? hit_cnt_reg : hit_cnt_reg + 1'b1;
        ref_cnt_inc = (ref_cnt_reg == '1) ? ref_cnt_reg : ref_cnt_reg + 1'b1;
    end

    always_comb begin
        state_next   = state_reg;
        pg_next      = pg_reg;
        cnt_next     = cnt_reg;
        used_next    = used_reg;
        hit_next     = hit_reg;
        evv_next     = evv_reg;
        evp_next     = evp_reg;
        hit_cnt_next = hit_cnt_reg;
        ref_cnt_next = ref_cnt_reg;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = cnt_reg[IDX_W-1:0];
        mem_wr_data  = pg_reg;
        mem_rd_addr  = cnt_reg[IDX_W-1:0];
        in_ready     = 1'b0;
        res_valid    = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    hit_next = 1'b0;
                    evv_next = 1'b0;
                    evp_next = '0;
                    cnt_next = '0;
                    if (in_kind == KIND_CLEAR) begin
                        pg_next      = '0;
                        used_next    = '0;
                        hit_cnt_next = '0;
                        ref_cnt_next = '0;
                        state_next   = S_DONE;
                    end else begin
                        pg_next    = page_calc;
                        state_next = S_SRCH_RD;
                    end
                end
            end
            S_SRCH_RD: begin
                if (cnt_reg == used_reg) begin
                    if (used_reg < lim) begin
                        mem_wr_en    = 1'b1;
                        mem_wr_addr  = used_reg[IDX_W-1:0];
                        used_next    = used_reg + 1'b1;
                        ref_cnt_next = ref_cnt_inc;
                        state_next   = S_DONE;
                    end else begin
                        evv_next   = 1'b1;
                        cnt_next   = '0;
                        state_next = S_SH_RD;
                    end
                end else begin
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                if (cnt_reg == '0) begin
                    evp_next = mem_rd_data;
                end
                if (mem_rd_data == pg_reg) begin
                    hit_next     = 1'b1;
                    hit_cnt_next = hit_cnt_inc;
                    state_next   = S_SH_RD;
                end else begin
                    cnt_next   = cnt_p1;
                    state_next = S_SRCH_RD;
                end
            end
            S_SH_RD: begin
                mem_rd_addr = cnt_p1[IDX_W-1:0];
                if (cnt_reg < used_m1) begin
                    state_next = S_SH_WR;
                end else begin
                    mem_wr_en    = 1'b1;
                    mem_wr_addr  = used_m1[IDX_W-1:0];
                    ref_cnt_next = ref_cnt_inc;
                    state_next   = S_DONE;
                end
            end
            S_SH_WR: begin
                mem_wr_en   = 1'b1;
                mem_wr_data = mem_rd_data;
                cnt_next    = cnt_p1;
                state_next  = S_SH_RD;
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            hit_cnt_reg <= '0;
            ref_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            hit_cnt_reg <= hit_cnt_next;
            ref_cnt_reg <= ref_cnt_next;
        end
        pg_reg  <= pg_next;
        cnt_reg <= cnt_next;
        hit_reg <= hit_next;
        evv_reg <= evv_next;
        evp_reg <= evp_next;
    end

    assign res_hit       = hit_reg;
    assign res_page      = pg_reg;
    assign res_ev_valid  = evv_reg;
    assign res_ev_page   = evv_reg ? evp_reg : '0;
    assign res_hit_total = hit_cnt_reg;
    assign res_ref_total = ref_cnt_reg;

endmodule

@@ hw/rtl/lru_page_replacement.sv @@
// A reference searches the stack, then a hit shifts the entries above it down, a miss fills a
// free entry or, with all frames in use, shifts the stack to evict the oldest page; a clear goes
// straight to the result. Each search or shift step reads one stack entry, then compares or writes it.
// A new item is taken no earlier than the cycle after the previous result enters the output register.
// Reset (aresetn low, synchronous) empties the stack, zeroes both counters and the
// output valid, and sets page_size_log2 to 0 and frames_assigned to 4.
module lru_page_replacement #(
    parameter int MAX_FRAMES   = lrup_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS    = lrup_pkg::PAGE_BITS_DEF,
    parameter int ADDRESS_BITS = lrup_pkg::ADDRESS_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lrup_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lrup_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // address
    input  logic [((ADDRESS_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // kind
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // hit, page_number, evicted_valid, evicted_page, hit_total, reference_total
    output logic [((2 * PAGE_BITS + 2 + 2 * lrup_pkg::COUNT_W + 7) / 8) * 8 - 1:0] m_tdata
);
    import lrup_pkg::*;

    localparam int OUT_W = ((2 * PAGE_BITS + 2 + 2 * COUNT_W + 7) / 8) * 8;
    localparam int RES_W = 2 * PAGE_BITS + 2 + 2 * COUNT_W;

    lrup_cfg_t        cfg_reg, cfg_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;

    logic                 res_valid;
    logic                 res_ready;
    logic                 res_hit;
    logic [PAGE_BITS-1:0] res_page;
    logic                 res_ev_valid;
    logic [PAGE_BITS-1:0] res_ev_page;
    logic [COUNT_W-1:0]   res_hit_total;
    logic [COUNT_W-1:0]   res_ref_total;
    logic [RES_W-1:0]     res_packed;

    lrup_seq #(
        .MAX_FRAMES   (MAX_FRAMES),
        .PAGE_BITS    (PAGE_BITS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_kind       (s_tuser),
        .in_address    (s_tdata[ADDRESS_BITS-1:0]),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_hit       (res_hit),
        .res_page      (res_page),
        .res_ev_valid  (res_ev_valid),
        .res_ev_page   (res_ev_page),
        .res_hit_total (res_hit_total),
        .res_ref_total (res_ref_total)
    );

    assign cfg_ready  = 1'b1;
    assign res_ready  = !m_tvalid_reg || m_tready;
    assign res_packed = {res_ref_total, res_hit_total, res_ev_page, res_ev_valid,
                         res_page, res_hit};

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_PAGE_SIZE_LOG2:  cfg_next.page_size_log2  = cfg_data[PSL_W-1:0];
                CFG_FRAMES_ASSIGNED: cfg_next.frames_assigned = cfg_data[FA_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end

        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_W'(res_packed);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.page_size_log2  <= PSL_RESET;
            cfg_reg.frames_assigned <= FA_RESET;
            m_tvalid_reg            <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ hw/rtl/lrup_checker.sv @@
// Port-level checker of the LRU page replacement block and its bind statement.
`include "lru_page_replacement_macros.svh"

module lrup_checker #(
    parameter int PAGE_BITS = lrup_pkg::PAGE_BITS_DEF,
    parameter int OUT_W     = 48
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);
    import lrup_pkg::*;

    localparam int EVV_POS = PAGE_BITS + 1;
    localparam int EVP_LO  = PAGE_BITS + 2;
    localparam int HT_LO   = 2 * PAGE_BITS + 2;
    localparam int RT_LO   = HT_LO + COUNT_W;

    logic                 out_hit;
    logic                 out_evv;
    logic [PAGE_BITS-1:0] out_evp;
    logic [COUNT_W-1:0]   out_ht;
    logic [COUNT_W-1:0]   out_rt;

    assign out_hit = m_tdata[0];
    assign out_evv = m_tdata[EVV_POS];
    assign out_evp = m_tdata[EVP_LO +: PAGE_BITS];
    assign out_ht  = m_tdata[HT_LO +: COUNT_W];
    assign out_rt  = m_tdata[RT_LO +: COUNT_W];

    `LRUP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
                      m_tvalid && $stable(m_tdata))
    `LRUP_ASSERT_NOW(a_hit_no_evict, aclk, aresetn, m_tvalid && out_hit, !out_evv)
    `LRUP_ASSERT_NOW(a_evict_page_zero, aclk, aresetn, m_tvalid && !out_evv, out_evp == '0)
    `LRUP_ASSERT_NOW(a_hits_within_refs, aclk, aresetn, m_tvalid, out_ht <= out_rt)

endmodule

bind lru_page_replacement lrup_checker #(
    .PAGE_BITS (PAGE_BITS),
    .OUT_W     (((2 * PAGE_BITS + 2 + 2 * lrup_pkg::COUNT_W + 7) / 8) * 8)
) u_lrup_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ test/tb_lru_page_replacement.sv @@
// Self-checking testbench for the LRU page replacement block with a class-based scoreboard.
module tb_lru_page_replacement;
    import lrup_pkg::*;

    localparam int          SETTLE_CYCLES = 4 * MAX_FRAMES_DEF + 8;
    localparam int unsigned COUNT_LIMIT   = (1 << COUNT_W) - 1;
    localparam int          PRINT_LIMIT   = 40;

    typedef struct packed {
        logic [COUNT_W-1:0]       reference_total;
        logic [COUNT_W-1:0]       hit_total;
        logic [PAGE_BITS_DEF-1:0] evicted_page;
        logic                     evicted_valid;
        logic [PAGE_BITS_DEF-1:0] page_number;
        logic                     hit;
    } page_result_t;

    class lru_scoreboard;
        logic [PAGE_BITS_DEF-1:0] resident [MAX_FRAMES_DEF];
        int unsigned              used;
        int unsigned              hits;
        int unsigned              refs;
        logic [PSL_W-1:0]         psl;
        logic [FA_W-1:0]          fa;
        page_result_t             expected_q [$];
        int                       errors;

        function new();
            clear_run();
            psl    = PSL_RESET;
            fa     = FA_RESET;
            errors = 0;
        endfunction

        function void clear_run();
            foreach (resident[i]) resident[i] = '0;
            used = 0;
            hits = 0;
            refs = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_config(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_PAGE_SIZE_LOG2: begin
                    psl = value[PSL_W-1:0];
                end
                CFG_FRAMES_ASSIGNED: begin
                    fa = value[FA_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function void note_input(logic kind, logic [ADDRESS_BITS_DEF-1:0] addr);
            page_result_t r;
            int unsigned  pg;
            int unsigned  lim;
            int unsigned  pos;
            r = '0;
            if (kind == KIND_CLEAR) begin
                clear_run();
                expected_q.push_back(r);
                return;
            end
            if (addr == 0) pg = 1;
            else pg = ((int'(addr) - 1) >> (KB_SHIFT + psl)) + 1;
            pg  = pg & ((1 << PAGE_BITS_DEF) - 1);
            lim = (fa == 0) ? 1 : ((fa > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : fa);
            pos = used;
            for (int i = 0; i < used; i++) begin
                if (resident[i] == pg) begin
                    pos = i;
                    break;
                end
            end
            if (pos < used) begin
                r.hit = 1'b1;
                for (int i = pos; i + 1 < used; i++) resident[i] = resident[i + 1];
                resident[used - 1] = PAGE_BITS_DEF'(pg);
                if (hits < COUNT_LIMIT) hits++;
            end else if (used < lim) begin
                resident[used] = PAGE_BITS_DEF'(pg);
                used++;
            end else begin
                r.evicted_valid = 1'b1;
                r.evicted_page  = resident[0];
                for (int i = 0; i + 1 < used; i++) resident[i] = resident[i + 1];
                resident[used - 1] = PAGE_BITS_DEF'(pg);
            end
            if (refs < COUNT_LIMIT) refs++;
            r.page_number     = PAGE_BITS_DEF'(pg);
            r.hit_total       = COUNT_W'(hits);
            r.reference_total = COUNT_W'(refs);
            expected_q.push_back(r);
        endfunction

        task report(string what);
            errors++;
            if (errors <= PRINT_LIMIT) $display("ERROR at %0t: %s", $time, what);
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want) report($sformatf("%s: got %0d, expected %0d", name, got, want));
        endtask

        task check_result(logic [47:0] data);
            page_result_t got;
            page_result_t want;
            got = page_result_t'(data[$bits(page_result_t)-1:0]);
            if (expected_q.size() == 0) begin
                report("result transfer with no result expected");
                return;
            end
            want = expected_q.pop_front();
            compare_field("hit", got.hit, want.hit);
            compare_field("page_number", got.page_number, want.page_number);
            compare_field("evicted_valid", got.evicted_valid, want.evicted_valid);
            compare_field("evicted_page", got.evicted_page, want.evicted_page);
            compare_field("hit_total", got.hit_total, want.hit_total);
            compare_field("reference_total", got.reference_total, want.reference_total);
        endtask
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [47:0]            m_tdata;

    logic          gaps_on   = 1'b1;
    logic          stalls_on = 1'b1;
    lru_scoreboard sb;

    lru_page_replacement i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready = !stalls_on || ($urandom_range(99) >= 29);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    task automatic send_item(logic kind, logic [ADDRESS_BITS_DEF-1:0] addr);
        int gap;
        gap = 0;
        if (gaps_on) begin
            if ($urandom_range(49) == 0) gap = $urandom_range(140, 1);
            else while ($urandom_range(99) < 29) gap++;
        end
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {1'b0, addr};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(kind, addr);
        @(negedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        sb.note_config(idx, value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic reference(logic [ADDRESS_BITS_DEF-1:0] addr);
        send_item(KIND_REFERENCE, addr);
    endtask

    task automatic random_burst(int count);
        int unsigned bytes;
        int unsigned maxp;
        int unsigned ws;
        int unsigned base;
        int unsigned pg;
        int unsigned a;
        int unsigned roll;
        bytes = 1024 << sb.psl;
        maxp  = MAX_FRAMES_DEF >> sb.psl;
        ws    = 1;
        base  = 0;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                ws   = $urandom_range(maxp, 1);
                base = $urandom_range(maxp - 1);
            end
            roll = $urandom_range(99);
            if (roll < 2) begin
                send_item(KIND_CLEAR, ADDRESS_BITS_DEF'($urandom));
            end else if (roll < 4) begin
                reference('0);
            end else if (roll < 14) begin
                reference(ADDRESS_BITS_DEF'($urandom_range(32767)));
            end else begin
                pg = (base + $urandom_range(ws - 1)) % maxp + 1;
                a  = (pg - 1) * bytes + $urandom_range(bytes, 1);
                if (a > 32767) a = 32767;
                reference(ADDRESS_BITS_DEF'(a));
            end
        end
    endtask

    initial begin
        logic [PSL_W-1:0] psl_list [10];
        logic [FA_W-1:0]  fa_list  [10];
        psl_list = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1, 2'd3, 2'd0, 2'd1};
        fa_list  = '{6'd32, 6'd2, 6'd0, 6'd63, 6'd1, 6'd33, 6'd5, 6'd16, 6'd31, 6'd8};
        sb = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset configuration: 1K pages, four frames.
        reference(15'd0);
        reference(15'd1);
        reference(15'd1024);
        reference(15'd1025);
        reference(15'd2049);
        reference(15'd3073);
        reference(15'd4097);
        reference(15'd1025);
        reference(15'd32767);
        send_item(KIND_CLEAR, 15'h7FFF);
        reference(15'd32767);
        drain();

        write_reg(CFG_PAGE_SIZE_LOG2, 6'h3F);
        write_reg(CFG_FRAMES_ASSIGNED, 6'd0);
        reference(15'd8192);
        reference(15'd8193);
        reference(15'd32767);
        reference(15'd24577);
        reference(15'd0);
        send_item(KIND_CLEAR, 15'd0);
        drain();

        for (int p = 0; p < 13; p++) begin
            gaps_on   = (p != 0);
            stalls_on = (p != 0);
            if (p < 10) begin
                write_reg(CFG_PAGE_SIZE_LOG2, {4'($urandom), psl_list[p]});
                write_reg(CFG_FRAMES_ASSIGNED, fa_list[p]);
            end else begin
                write_reg(CFG_PAGE_SIZE_LOG2, CFG_DATA_W'($urandom));
                write_reg(CFG_FRAMES_ASSIGNED, CFG_DATA_W'($urandom));
            end
            random_burst(145);
            drain();
        end

        if (sb.errors == 0) begin
            $display("lru_page_replacement: match");
        end else begin
            $display("lru_page_replacement: mismatch");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("lru_page_replacement: mismatch");
        $finish;
    end

endmodule
